>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define WSDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define WSDF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wsdf_pkg.sv
// types and constants for the websocket frame deframer
// no dependencies; used by the result and config channel interfaces and the top level
`default_nettype none

package wsdf_pkg;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_PONG  = 2'd1,
		KIND_CLOSE = 2'd2,
		KIND_BIG   = 2'd3
	} kind_t;

	typedef logic [3:0] opcode_t;

	localparam opcode_t OP_DATA_MAX = 4'h2;
	localparam opcode_t OP_CLOSE    = 4'h8;
	localparam opcode_t OP_PING     = 4'h9;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned LEN_W = 64;

	localparam logic [CFG_W-1:0] MAX_FRAME_LEN_RST = CFG_W'(2 * 1024 * 1024);

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

`default_nettype wire

>>> rtl/wsdf_in_if.sv
// input byte channel of the websocket frame deframer
// depends on nothing but valid/ready handshake conventions
`default_nettype none

interface wsdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/wsdf_out_if.sv
// result channel of the websocket frame deframer
// depends on wsdf_pkg for the result kind type
`default_nettype none

interface wsdf_out_if;
	logic              valid;
	logic              ready;
	wsdf_pkg::kind_t   kind;
	logic [7:0]        payload_byte;
	logic              has_byte;
	logic              last;

	modport source (output valid, output kind, output payload_byte, output has_byte,
		output last, input ready);
	modport sink   (input valid, input kind, input payload_byte, input has_byte,
		input last, output ready);
endinterface

`default_nettype wire

>>> rtl/wsdf_cfg_if.sv
// configuration write channel carrying max_frame_len
// depends on wsdf_pkg for the register width
`default_nettype none

interface wsdf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [wsdf_pkg::CFG_W-1:0] max_frame_len;

	modport source (output valid, output max_frame_len, input ready);
	modport sink   (input valid, input max_frame_len, output ready);
endinterface

`default_nettype wire

>>> rtl/websocket_frame_deframer_top.sv
// websocket frame deframer, receive side: one stream byte per beat in, at most one result out.
// depends on wsdf_pkg, wsdf_in_if, wsdf_out_if, wsdf_cfg_if and assert_macros.svh.
// A byte is taken into an input register, the frame parser updates its state from it and
// loads any result into an output register, so a byte is accepted in every cycle while
// the result side takes beats. The rate is set by the update of the 64-bit remaining length
// counter and the length check against max_frame_len. Data frames give unmasked payload
// bytes, pings give raw pong bytes or a bare marker, close frames and oversize lengths give a
// marker and then the block drops every byte until reset. The user must write max_frame_len
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer_top (
	input  wire         clk,
	input  wire         arst_n,
	wsdf_in_if.sink     in_ch,
	wsdf_out_if.source  out_ch,
	wsdf_cfg_if.sink    cfg
);
	import wsdf_pkg::*;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// configuration
	logic [CFG_W-1:0] max_len_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       in_take;

	// parser state
	phase_t           phase_q, phase_nxt;
	opcode_t          opcode_q, opcode_nxt;
	logic             mask_q, mask_nxt;
	logic [LEN_W-1:0] rem_q, rem_nxt;
	logic [3:0]       hcnt_q, hcnt_nxt;
	logic [31:0]      key_q, key_nxt;
	logic [1:0]       mask_pos_q, mask_pos_nxt;
	logic             halted_q, halted_nxt;

	// result register
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] pbyte_q;
	logic       has_q;
	logic       last_q;

	// next result
	logic             res_load;
	kind_t            res_kind;
	logic [7:0]       res_byte;
	logic             res_has;
	logic             res_last;

	logic             len_done;
	logic             body_go;
	logic [LEN_W-1:0] len_new;
	logic [LEN_W-1:0] rem_dec;
	logic             fin;

	assign advance   = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take   = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	assign rem_dec = rem_q - LEN_W'(1);
	assign fin     = (rem_dec == '0);

	always_comb begin
		phase_nxt    = phase_q;
		opcode_nxt   = opcode_q;
		mask_nxt     = mask_q;
		rem_nxt      = rem_q;
		hcnt_nxt     = hcnt_q;
		key_nxt      = key_q;
		mask_pos_nxt = mask_pos_q;
		halted_nxt   = halted_q;
		res_load     = 1'b0;
		res_kind     = KIND_DATA;
		res_byte     = 8'h00;
		res_has      = 1'b0;
		res_last     = 1'b0;
		len_done     = 1'b0;
		body_go      = 1'b0;
		len_new      = '0;

		if (advance && !halted_q) begin
			case (phase_q)
				PH_HDR0: begin
					opcode_nxt   = byte_s1[3:0];
					key_nxt      = '0;
					mask_pos_nxt = '0;
					rem_nxt      = '0;
					phase_nxt    = PH_HDR1;
				end
				PH_HDR1: begin
					mask_nxt = byte_s1[7];
					rem_nxt  = '0;
					if (byte_s1[6:0] == LEN7_EXT16 || byte_s1[6:0] == LEN7_EXT64) begin
						hcnt_nxt  = (byte_s1[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
						phase_nxt = PH_EXTLEN;
					end else begin
						len_new  = {{(LEN_W-7){1'b0}}, byte_s1[6:0]};
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					len_new  = {rem_q[LEN_W-9:0], byte_s1};
					rem_nxt  = len_new;
					hcnt_nxt = hcnt_q - 4'd1;
					if (hcnt_nxt == 4'd0) begin
						len_done = 1'b1;
					end
				end
				PH_MASK: begin
					key_nxt[{mask_pos_q, 3'b000} +: 8] = byte_s1;
					mask_pos_nxt = mask_pos_q + 2'd1;
					if (mask_pos_nxt == 2'd0) begin
						body_go = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					rem_nxt = rem_dec;
					if (fin) begin
						phase_nxt = PH_HDR0;
					end
					if (opcode_q <= OP_DATA_MAX) begin
						mask_pos_nxt = mask_pos_q + 2'd1;
						res_load = 1'b1;
						res_kind = KIND_DATA;
						res_byte = byte_s1 ^ key_q[{mask_pos_q, 3'b000} +: 8];
						res_has  = 1'b1;
						res_last = fin;
					end else if (opcode_q == OP_PING) begin
						res_load = 1'b1;
						res_kind = KIND_PONG;
						res_byte = byte_s1;
						res_has  = 1'b1;
						res_last = fin;
					end else if (opcode_q == OP_CLOSE && fin) begin
						halted_nxt = 1'b1;
						res_load   = 1'b1;
						res_kind   = KIND_CLOSE;
						res_last   = 1'b1;
					end
				end
				default: begin
					phase_nxt = PH_HDR0;
				end
			endcase

			// length field complete: size check, then mask key or body
			if (len_done) begin
				rem_nxt = len_new;
				if ((|len_new[LEN_W-1:CFG_W]) || (len_new[CFG_W-1:0] > max_len_q)) begin
					halted_nxt = 1'b1;
					phase_nxt  = PH_HDR0;
					res_load   = 1'b1;
					res_kind   = KIND_BIG;
					res_last   = 1'b1;
				end else if (mask_nxt) begin
					mask_pos_nxt = '0;
					phase_nxt    = PH_MASK;
				end else begin
					body_go = 1'b1;
				end
			end

			// header fully read: empty frames finish here
			if (body_go) begin
				if (rem_nxt != '0) begin
					phase_nxt = PH_PAYLOAD;
				end else begin
					phase_nxt = PH_HDR0;
					if (opcode_q == OP_CLOSE) begin
						halted_nxt = 1'b1;
						res_load   = 1'b1;
						res_kind   = KIND_CLOSE;
						res_last   = 1'b1;
					end else if (opcode_q == OP_PING) begin
						res_load = 1'b1;
						res_kind = KIND_PONG;
						res_last = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_FRAME_LEN_RST;
		end else if (cfg.valid && cfg.ready) begin
			max_len_q <= cfg.max_frame_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			opcode_q   <= '0;
			mask_q     <= 1'b0;
			rem_q      <= '0;
			hcnt_q     <= '0;
			key_q      <= '0;
			mask_pos_q <= '0;
			halted_q   <= 1'b0;
		end else begin
			phase_q    <= phase_nxt;
			opcode_q   <= opcode_nxt;
			mask_q     <= mask_nxt;
			rem_q      <= rem_nxt;
			hcnt_q     <= hcnt_nxt;
			key_q      <= key_nxt;
			mask_pos_q <= mask_pos_nxt;
			halted_q   <= halted_nxt;
		end
	end

	// result register: the old beat is gone or leaves whenever advance is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_load;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_load) begin
			kind_q  <= res_kind;
			pbyte_q <= res_byte;
			has_q   <= res_has;
			last_q  <= res_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = kind_q;
	assign out_ch.payload_byte = pbyte_q;
	assign out_ch.has_byte     = has_q;
	assign out_ch.last         = last_q;

	`WSDF_ASSERT(a_halt_silent, halted_q && !out_valid_q |=> !out_valid_q, "result after halt")
	`WSDF_ASSERT(a_marker_shape,
		out_valid_q && (kind_q == KIND_CLOSE || kind_q == KIND_BIG) |-> !has_q && last_q,
		"close or oversize marker carries a byte")
	`WSDF_ASSERT(a_ext_mask_pos, phase_q == PH_EXTLEN |-> mask_pos_q == 2'd0, "mask position moved during length bytes")
	// held low across an edge, so the registers are already cleared
	`WSDF_ASSERT_ALWAYS(a_rst_quiet, !arst_n ##1 !arst_n |-> !out_valid_q && !valid_s1, "valid during reset")

endmodule

`default_nettype wire
